@@ src/tnc_pkg.sv @@
package tnc_pkg;

   localparam int COORD_WIDTH_DEF = 32;   // default coordinate width, Q16.16
   localparam int NORM_BITS       = 15;   // magnitude bits of a Q2.14 normal component
   localparam int UNIT_SHIFT      = 30;   // 2 * 15, scale of the squared component
   localparam int MUL_LAT         = 2;    // split multiplier latency
   localparam int NORM_LAT        = NORM_BITS + 1;

   // operand pairs of the six cross-product terms, edges ordered bx by bz ax ay az
   function automatic int prod_a_idx(input int j);
      case (j)
         0: return 1;
         1: return 2;
         2: return 2;
         3: return 0;
         4: return 0;
         5: return 1;
         default: return 0;
      endcase
   endfunction

   function automatic int prod_b_idx(input int j);
      case (j)
         0: return 5;
         1: return 4;
         2: return 3;
         3: return 5;
         4: return 4;
         5: return 3;
         default: return 0;
      endcase
   endfunction

endpackage

@@ src/tnc_delay.sv @@
module tnc_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] d,
   output logic [WIDTH-1:0] q
);

   logic [WIDTH-1:0] tap_ff [DEPTH];

   for (genvar k = 0; k < DEPTH; k++) begin : g_tap
      if (k == 0) begin : g_head
         always_ff @(posedge clock) begin
            if (en) tap_ff[0] <= d;
         end
      end else begin : g_body
         always_ff @(posedge clock) begin
            if (en) tap_ff[k] <= tap_ff[k-1];
         end
      end
   end

   assign q = tap_ff[DEPTH-1];

endmodule

@@ src/tnc_mul.sv @@
module tnc_mul #(
   parameter int AW = 33
) (
   input  logic            clock,
   input  logic            en,
   input  logic [AW-1:0]   a,
   input  logic [AW-1:0]   b,
   output logic [2*AW-1:0] p
);

   localparam int H = (AW + 1) / 2;

   logic [H-1:0]    a_lo, a_hi, b_lo, b_hi;
   logic [2*H-1:0]  ll_ff, lh_ff, hl_ff, hh_ff;
   logic [4*H-1:0]  sum;
   logic [2*AW-1:0] p_in, p_ff;

   assign a_lo = a[H-1:0];
   assign b_lo = b[H-1:0];
   assign a_hi = H'(a[AW-1:H]);
   assign b_hi = H'(b[AW-1:H]);

   // partial products, then recombine
   always_ff @(posedge clock) begin
      if (en) begin
         ll_ff <= (2*H)'(a_lo) * (2*H)'(b_lo);
         lh_ff <= (2*H)'(a_lo) * (2*H)'(b_hi);
         hl_ff <= (2*H)'(a_hi) * (2*H)'(b_lo);
         hh_ff <= (2*H)'(a_hi) * (2*H)'(b_hi);
      end
   end

   always_comb begin
      sum  = (4*H)'(ll_ff) + ((4*H)'(lh_ff) << H) + ((4*H)'(hl_ff) << H)
           + ((4*H)'(hh_ff) << (2*H));
      p_in = sum[2*AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) p_ff <= p_in;
   end

   assign p = p_ff;

endmodule

@@ src/tnc_norm.sv @@
module tnc_norm #(
   parameter int SW = 132
) (
   input  logic                         clock,
   input  logic                         en,
   input  logic [SW-1:0]                s,
   input  logic [SW-1:0]                c2,
   output logic [tnc_pkg::NORM_BITS-1:0] q
);

   import tnc_pkg::*;

   localparam int NB = NORM_BITS;
   localparam int XW = SW + UNIT_SHIFT + 4;

   // l = (2q-1)^2 * S, m = (2q-1) * S, t = c^2 << 30
   logic signed [XW-1:0] l_ff [NB];
   logic signed [XW-1:0] m_ff [NB];
   logic signed [XW-1:0] s_ff [NB];
   logic signed [XW-1:0] t_ff [NB];
   logic [NB-1:0]        q_ff [NB+1];

   always_ff @(posedge clock) begin
      if (en) begin
         l_ff[0] <= XW'(s);
         m_ff[0] <= -(XW'(s));
         s_ff[0] <= XW'(s);
         t_ff[0] <= XW'(c2) << UNIT_SHIFT;
         q_ff[0] <= '0;
      end
   end

   for (genvar k = 0; k < NB; k++) begin : g_step
      localparam int B = NB - 1 - k;
      logic signed [XW-1:0] cand;
      logic                 take;

      always_comb begin
         cand = l_ff[k] + (m_ff[k] <<< (B + 2)) + (s_ff[k] <<< (2 * B + 2));
         take = (cand <= t_ff[k]);
      end

      always_ff @(posedge clock) begin
         if (en) q_ff[k+1] <= take ? (q_ff[k] | (NB'(1) << B)) : q_ff[k];
      end

      if (k < NB - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               l_ff[k+1] <= take ? cand : l_ff[k];
               m_ff[k+1] <= take ? (m_ff[k] + (s_ff[k] <<< (B + 1))) : m_ff[k];
               s_ff[k+1] <= s_ff[k];
               t_ff[k+1] <= t_ff[k];
            end
         end
      end
   end

   assign q = q_ff[NB];

endmodule

@@ src/triangle_normal_and_centroid.sv @@
// Triangle face normal and centroid. One triangle (three vertices, signed
// Q16.16) enters per cycle whenever the pipeline advances; with
// rsp_tready held high the block sustains one triangle per clock. The
// pipeline consists of the edge differences, the split 2-stage
// multipliers for the cross product and for its squares, the cross
// and length stages, the 16-stage restoring square-root search that
// yields each Q2.14 normal component exactly rounded, and the output
// register. The centroid is (p1+p2+p3)/3 rounded to nearest, taken by
// reciprocal multiply. A triangle whose cross product is zero returns a
// zero normal with rsp_tuser set; its centroid is still valid. A stalled
// rsp channel freezes the whole pipeline; nothing is dropped or repeated.
module triangle_normal_and_centroid #(
   parameter int COORD_WIDTH = tnc_pkg::COORD_WIDTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, v3_x, v3_y, v3_z (32 bits each)
   input  logic [287:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // center_x, center_y, center_z (32 bits), normal_x, normal_y, normal_z (16)
   output logic [143:0] rsp_tdata,
   // degenerate
   output logic         rsp_tuser
);

   import tnc_pkg::*;

   localparam int W   = COORD_WIDTH;
   localparam int DW  = W + 1;          // edge difference, signed
   localparam int CW  = 2 * W + 3;      // cross component, signed
   localparam int CM  = 2 * W + 2;      // cross magnitude
   localparam int SW  = 2 * CM;         // squared length
   localparam int CN  = W + 2;          // biased centroid sum
   localparam int LAT = 8 + NORM_LAT + 1;
   localparam int CTR_DLY = 2 + MUL_LAT + NORM_LAT;
   localparam int SGN_DLY = 1 + MUL_LAT + NORM_LAT;
   localparam logic [63:0] RECIP_WIDE = ((64'd1 << (W + 3)) + 64'd2) / 64'd3;
   localparam logic [CN-1:0] RECIP = RECIP_WIDE[CN-1:0];
   localparam logic signed [W+2:0] CBIAS = (W + 3)'(3) <<< (W - 1);
   localparam logic signed [W+1:0] CUNBIAS = (W + 2)'(1) <<< (W - 1);

   logic en;
   logic [LAT-1:0] vld_ff;

   logic signed [W-1:0]  crd [9];
   logic signed [DW-1:0] diff [6];
   logic signed [W+2:0]  csum [3];

   logic [DW-1:0]       dmag_ff [6];
   logic [5:0]          dsgn_ff;
   logic [CN-1:0]       cu_ff [3];

   logic [2*DW-1:0]     prod [6];
   logic [5:0]          psgn;
   logic [2*CN-1:0]     cprod [3];

   logic signed [CW-1:0] cross_ff [3];
   logic [95:0]          ctr_ff;
   logic [CM-1:0]        cmag_ff [3];
   logic [2:0]           csgn_ff;
   logic [SW-1:0]        sq [3];
   logic [SW-1:0]        s_ff;
   logic [SW-1:0]        c2_ff [3];
   logic                 deg_ff;

   logic [NORM_BITS-1:0] nq [3];
   logic [95:0]          ctr_d;
   logic [2:0]           csgn_d;
   logic                 deg_d;

   logic [143:0]         out_ff;
   logic                 out_deg_ff;

   // advance every stage together whenever the output slot is free or taken
   assign en         = !vld_ff[LAT-1] || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = vld_ff[LAT-1];
   assign rsp_tdata  = out_ff;
   assign rsp_tuser  = out_deg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], req_tvalid};
      end
   end

   // stage A: coordinates, edges from p2, biased centroid sums
   always_comb begin
      logic [W+31:0] ext;
      for (int i = 0; i < 9; i++) begin
         ext    = {{W{1'b0}}, req_tdata[32*i +: 32]};
         crd[i] = ext[W-1:0];
      end
      diff[0] = DW'(crd[0]) - DW'(crd[3]);
      diff[1] = DW'(crd[1]) - DW'(crd[4]);
      diff[2] = DW'(crd[2]) - DW'(crd[5]);
      diff[3] = DW'(crd[6]) - DW'(crd[3]);
      diff[4] = DW'(crd[7]) - DW'(crd[4]);
      diff[5] = DW'(crd[8]) - DW'(crd[5]);
      for (int i = 0; i < 3; i++) begin
         csum[i] = (W + 3)'(crd[i]) + (W + 3)'(crd[i+3]) + (W + 3)'(crd[i+6])
                 + (W + 3)'(1) + CBIAS;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < 6; j++) begin
            dmag_ff[j] <= diff[j][DW-1] ? DW'(-diff[j]) : DW'(diff[j]);
            dsgn_ff[j] <= diff[j][DW-1];
         end
         for (int i = 0; i < 3; i++) cu_ff[i] <= csum[i][CN-1:0];
      end
   end

   // stages B, C: cross-product terms and centroid reciprocal products
   for (genvar j = 0; j < 6; j++) begin : g_prod
      localparam int IA = prod_a_idx(j);
      localparam int IB = prod_b_idx(j);
      tnc_mul #(.AW(DW)) u_mul (
         .clock (clock),
         .en    (en),
         .a     (dmag_ff[IA]),
         .b     (dmag_ff[IB]),
         .p     (prod[j])
      );
   end

   tnc_delay #(.WIDTH(6), .DEPTH(MUL_LAT)) u_psgn (
      .clock (clock),
      .en    (en),
      .d     ({dsgn_ff[1] ^ dsgn_ff[3], dsgn_ff[0] ^ dsgn_ff[4],
               dsgn_ff[0] ^ dsgn_ff[5], dsgn_ff[2] ^ dsgn_ff[3],
               dsgn_ff[2] ^ dsgn_ff[4], dsgn_ff[1] ^ dsgn_ff[5]}),
      .q     (psgn)
   );

   for (genvar i = 0; i < 3; i++) begin : g_cmul
      tnc_mul #(.AW(CN)) u_mul (
         .clock (clock),
         .en    (en),
         .a     (cu_ff[i]),
         .b     (RECIP),
         .p     (cprod[i])
      );
   end

   // stage D: signed cross components, unbiased centroid
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            cross_ff[i] <= (psgn[2*i]   ? -CW'(prod[2*i])   : CW'(prod[2*i]))
                         - (psgn[2*i+1] ? -CW'(prod[2*i+1]) : CW'(prod[2*i+1]));
            ctr_ff[32*i +: 32] <= 32'(signed'((W + 2)'(cprod[i][2*CN-1:W+3])) - CUNBIAS);
         end
      end
   end

   // stage E: magnitude and sign of each component
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            cmag_ff[i] <= cross_ff[i][CW-1] ? CM'(-cross_ff[i]) : CM'(cross_ff[i]);
            csgn_ff[i] <= cross_ff[i][CW-1];
         end
      end
   end

   // stages F, G: squares
   for (genvar i = 0; i < 3; i++) begin : g_sq
      tnc_mul #(.AW(CM)) u_mul (
         .clock (clock),
         .en    (en),
         .a     (cmag_ff[i]),
         .b     (cmag_ff[i]),
         .p     (sq[i])
      );
   end

   // stage H: squared length and zero test
   always_ff @(posedge clock) begin
      logic [SW+1:0] tot;
      if (en) begin
         tot    = (SW + 2)'(sq[0]) + (SW + 2)'(sq[1]) + (SW + 2)'(sq[2]);
         s_ff   <= tot[SW-1:0];
         deg_ff <= (tot == '0);
         for (int i = 0; i < 3; i++) c2_ff[i] <= sq[i];
      end
   end

   // stages I: bit-by-bit exact rounding of 16384 * |c| / sqrt(S)
   for (genvar i = 0; i < 3; i++) begin : g_norm
      tnc_norm #(.SW(SW)) u_norm (
         .clock (clock),
         .en    (en),
         .s     (s_ff),
         .c2    (c2_ff[i]),
         .q     (nq[i])
      );
   end

   tnc_delay #(.WIDTH(96), .DEPTH(CTR_DLY)) u_ctr_dly (
      .clock (clock), .en (en), .d (ctr_ff), .q (ctr_d)
   );

   tnc_delay #(.WIDTH(3), .DEPTH(SGN_DLY)) u_sgn_dly (
      .clock (clock), .en (en), .d (csgn_ff), .q (csgn_d)
   );

   tnc_delay #(.WIDTH(1), .DEPTH(NORM_LAT)) u_deg_dly (
      .clock (clock), .en (en), .d (deg_ff), .q (deg_d)
   );

   // stage J: output register; drop the normal on a zero-area triangle
   always_ff @(posedge clock) begin
      logic [15:0] nv;
      if (en) begin
         out_ff[95:0] <= ctr_d;
         for (int i = 0; i < 3; i++) begin
            nv = 16'(nq[i]);
            out_ff[96 + 16*i +: 16] <= deg_d ? 16'd0 : (csgn_d[i] ? -nv : nv);
         end
         out_deg_ff <= deg_d;
      end
   end

`ifndef SYNTH
   a_deg_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[143:96] == 48'd0)
      else $error("degenerate result carries a nonzero normal");

   a_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[143:96] != 48'd0)
      else $error("valid triangle produced a zero normal");

   a_unit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[111:96]) <= 16384
                      && $signed(rsp_tdata[111:96]) >= -16384
                      && $signed(rsp_tdata[127:112]) <= 16384
                      && $signed(rsp_tdata[127:112]) >= -16384
                      && $signed(rsp_tdata[143:128]) <= 16384
                      && $signed(rsp_tdata[143:128]) >= -16384))
      else $error("normal component exceeds unit length");
`endif

endmodule
